// ===== rtl/voxel_line_traversal_3d_core_defines.svh =====
// -----------------------------------------------------------------------------
// voxel_line_traversal_3d_core_defines
// Assertion macros shared by the voxel line traversal modules.
// -----------------------------------------------------------------------------
`ifndef VOXEL_LINE_TRAVERSAL_3D_CORE_DEFINES_SVH
`define VOXEL_LINE_TRAVERSAL_3D_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define VLT3D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("voxel traversal check failed");

// Next-cycle implication, disabled while reset is asserted
`define VLT3D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("voxel traversal check failed");

`endif

// ===== rtl/vlt3d_pkg.sv =====
// -----------------------------------------------------------------------------
// vlt3d_pkg
// Types and fixed widths shared by the voxel line traversal controller,
// datapath and top level.
// -----------------------------------------------------------------------------
package vlt3d_pkg;

	localparam int COORD_W = 4;
	localparam int ACC_W   = 13;
	localparam int INC_W   = 9;
	localparam int PROD_W  = 8;
	localparam int STEP_W  = 6;

	// Step direction of one axis
	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_PLUS  = 2'd1,
		DIR_MINUS = 2'd2
	} dir_t;

	// Axis picked for the next step
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic advance;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;
	} dp_status_t;

endpackage

// ===== rtl/voxel_line_traversal_3d_core.sv =====
// -----------------------------------------------------------------------------
// voxel_line_traversal_3d_core
// 3D voxel line traversal: emits every voxel on the line between two cells.
// -----------------------------------------------------------------------------
// A request names a start cell and an end cell; coordinates at or above
// GRID_SIZE are saturated to GRID_SIZE - 1. The core returns one result per
// visited voxel, from the start cell to the end cell in 6-connected order,
// with is_last set on the end cell: |dx| + |dy| + |dz| + 1 results, at most 46.
// Results leave at one per cycle while the output is not stalled, since the
// datapath's single step unit advances one axis per cycle. A request is taken
// only while the core is idle, so a new request waits until the last result
// of the current run has been taken.

module voxel_line_traversal_3d_core
	import vlt3d_pkg::*;
#(
	parameter int GRID_SIZE = 16
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] start_z,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  logic [COORD_W-1:0] end_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COORD_W-1:0] voxel_x,
	output logic [COORD_W-1:0] voxel_y,
	output logic [COORD_W-1:0] voxel_z,
	output logic               is_last
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	// Run control
	vlt3d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Line setup and stepping
	vlt3d_dpath #(
		.GRID_SIZE (GRID_SIZE)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.start_x (start_x),
		.start_y (start_y),
		.start_z (start_z),
		.end_x   (end_x),
		.end_y   (end_y),
		.end_z   (end_z),
		.cmd     (cmd),
		.status  (status),
		.voxel_x (voxel_x),
		.voxel_y (voxel_y),
		.voxel_z (voxel_z),
		.is_last (is_last)
	);

endmodule

// ===== rtl/vlt3d_ctrl.sv =====
// -----------------------------------------------------------------------------
// vlt3d_ctrl
// Run controller: takes one request while idle, then hands out voxels one at
// a time until the last one is taken.
// -----------------------------------------------------------------------------
`include "voxel_line_traversal_3d_core_defines.svh"

module vlt3d_ctrl
	import vlt3d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output ctl_cmd_t   cmd,
	input  dp_status_t status
);

	state_t state_q;
	state_t state_d;
	logic   out_take;

	assign out_take = out_valid && !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_take && status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_EMIT: begin
				out_valid   = 1'b1;
				cmd.advance = out_take && !status.last;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`VLT3D_ASSERT_NEXT(a_load_starts_run, clk, arst_n, cmd.load, out_valid && in_stall)
	`VLT3D_ASSERT_NEXT(a_last_ends_run, clk, arst_n, out_take && status.last, !out_valid && !in_stall)
	`VLT3D_ASSERT_IMP(a_no_step_past_last, clk, arst_n, cmd.advance, !status.last && !cmd.load)

endmodule

// ===== rtl/vlt3d_dpath.sv =====
// -----------------------------------------------------------------------------
// vlt3d_dpath
// Traversal datapath: clamps and sets up the line, then steps one voxel per
// advance command along the axis with the smallest scaled crossing value.
// -----------------------------------------------------------------------------
`include "voxel_line_traversal_3d_core_defines.svh"

module vlt3d_dpath
	import vlt3d_pkg::*;
#(
	parameter int GRID_SIZE = 16
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] start_z,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  logic [COORD_W-1:0] end_z,
	input  ctl_cmd_t           cmd,
	output dp_status_t         status,
	output logic [COORD_W-1:0] voxel_x,
	output logic [COORD_W-1:0] voxel_y,
	output logic [COORD_W-1:0] voxel_z,
	output logic               is_last
);

	localparam logic [COORD_W:0]   GRID_LIM  = (COORD_W + 1)'(GRID_SIZE);
	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

	logic [COORD_W-1:0] s_c   [3];
	logic [COORD_W-1:0] e_c   [3];
	logic [COORD_W-1:0] ext   [3];
	logic [COORD_W-1:0] nz    [3];
	dir_t               dir_d [3];
	logic [PROD_W-1:0]  prod  [3];
	logic [STEP_W-1:0]  steps_d;

	logic [COORD_W-1:0] pos_q [3];
	logic [ACC_W-1:0]   acc_q [3];
	logic [INC_W-1:0]   inc_q [3];
	dir_t               dir_q [3];
	logic [STEP_W-1:0]  remain_q;

	logic  lt01;
	logic  lt02;
	logic  lt12;
	axis_t axis_sel;

	// Saturate a coordinate to the grid
	function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
		logic [COORD_W-1:0] r;
		r = v;
		if ({1'b0, v} >= GRID_LIM) begin
			r = COORD_MAX;
		end
		return r;
	endfunction

	// True when axis a crosses strictly before axis b; idle axes never win
	function automatic logic lt(input dir_t da, input dir_t db,
			input logic [ACC_W-1:0] aa, input logic [ACC_W-1:0] ab);
		logic r;
		if (da == DIR_NONE) begin
			r = 1'b0;
		end else if (db == DIR_NONE) begin
			r = 1'b1;
		end else begin
			r = aa < ab;
		end
		return r;
	endfunction

	// Move one cell along the given direction, wrapping at four bits
	function automatic logic [COORD_W-1:0] move(input logic [COORD_W-1:0] p, input dir_t d);
		logic [COORD_W-1:0] r;
		case (d)
			DIR_PLUS:  r = p + COORD_W'(1);
			DIR_MINUS: r = p - COORD_W'(1);
			default:   r = p;
		endcase
		return r;
	endfunction

	// Set up extents, directions and the per-axis product of the other extents
	always_comb begin
		s_c[0] = clamp(start_x);
		s_c[1] = clamp(start_y);
		s_c[2] = clamp(start_z);
		e_c[0] = clamp(end_x);
		e_c[1] = clamp(end_y);
		e_c[2] = clamp(end_z);
		for (int i = 0; i < 3; i++) begin
			if (e_c[i] > s_c[i]) begin
				ext[i]   = e_c[i] - s_c[i];
				dir_d[i] = DIR_PLUS;
			end else if (e_c[i] < s_c[i]) begin
				ext[i]   = s_c[i] - e_c[i];
				dir_d[i] = DIR_MINUS;
			end else begin
				ext[i]   = '0;
				dir_d[i] = DIR_NONE;
			end
			nz[i] = (ext[i] != '0) ? ext[i] : COORD_W'(1);
		end
		prod[0] = nz[1] * nz[2];
		prod[1] = nz[2] * nz[0];
		prod[2] = nz[0] * nz[1];
		steps_d = STEP_W'(ext[0]) + STEP_W'(ext[1]) + STEP_W'(ext[2]);
	end

	// Pick the axis to advance; ties go to Y over X, Z wins ties with the smaller
	always_comb begin
		lt01 = lt(dir_q[0], dir_q[1], acc_q[0], acc_q[1]);
		lt02 = lt(dir_q[0], dir_q[2], acc_q[0], acc_q[2]);
		lt12 = lt(dir_q[1], dir_q[2], acc_q[1], acc_q[2]);
		if (lt01) begin
			axis_sel = lt02 ? AXIS_X : AXIS_Z;
		end else begin
			axis_sel = lt12 ? AXIS_Y : AXIS_Z;
		end
	end

	// Load a new line or advance one voxel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				acc_q[i] <= '0;
				inc_q[i] <= '0;
				dir_q[i] <= DIR_NONE;
			end
			remain_q <= '0;
		end else if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= s_c[i];
				dir_q[i] <= dir_d[i];
				if (dir_d[i] != DIR_NONE) begin
					acc_q[i] <= ACC_W'(prod[i]);
					inc_q[i] <= {prod[i], 1'b0};
				end else begin
					acc_q[i] <= '0;
					inc_q[i] <= '0;
				end
			end
			remain_q <= steps_d;
		end else if (cmd.advance) begin
			for (int i = 0; i < 3; i++) begin
				if (axis_sel == axis_t'(i)) begin
					pos_q[i] <= move(pos_q[i], dir_q[i]);
					acc_q[i] <= acc_q[i] + ACC_W'(inc_q[i]);
				end
			end
			remain_q <= remain_q - STEP_W'(1);
		end
	end

	assign status.last = (remain_q == '0);
	assign voxel_x     = pos_q[0];
	assign voxel_y     = pos_q[1];
	assign voxel_z     = pos_q[2];
	assign is_last     = status.last;

	`VLT3D_ASSERT_NEXT(a_load_count, clk, arst_n, cmd.load, remain_q == $past(steps_d))
	`VLT3D_ASSERT_NEXT(a_advance_count, clk, arst_n, cmd.advance && !cmd.load, remain_q == $past(remain_q) - STEP_W'(1))
	`VLT3D_ASSERT_NEXT(a_advance_one_axis, clk, arst_n, cmd.advance && !cmd.load, (pos_q[0] == $past(pos_q[0])) || (pos_q[1] == $past(pos_q[1])))

endmodule

// ===== verif/tb_voxel_line_traversal_3d_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_voxel_line_traversal_3d_core
// Self-checking bench for the 3D voxel line traversal core.
// -----------------------------------------------------------------------------
// A table of directed paths (single-cell paths, grid corners, single-axis
// lines, full diagonals and crossing ties) runs first, then randomized
// requests. Every accepted request is expanded by an integer path predictor
// into its expected voxels, and each result from the core is compared
// against the oldest one. Both handshake sides idle at random, with one quiet
// stretch, one long output hold-off and one full drain of the sender.
// -----------------------------------------------------------------------------

module tb_voxel_line_traversal_3d_core
	import vlt3d_pkg::*;
();

	localparam int GRID_SIZE    = 16;
	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int NUM_RANDOM   = 440;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int MAX_REPORTS  = 10;
	localparam int NUM_DIRECTED = 21;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   last;
	} voxel_t;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t sz;
		coord_t ex;
		coord_t ey;
		coord_t ez;
		logic   typed;
		voxel_t want;
	} path_case_t;

	// Directed paths; single-cell rows carry their one result typed in
	path_case_t path_table [NUM_DIRECTED] = '{
		'{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b1, '{4'd0,  4'd0,  4'd0,  1'b1}},
		'{4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1, '{4'd15, 4'd15, 4'd15, 1'b1}},
		'{4'd5,  4'd10, 4'd3,  4'd5,  4'd10, 4'd3,  1'b1, '{4'd5,  4'd10, 4'd3,  1'b1}},
		'{4'd0,  4'd0,  4'd0,  4'd15, 4'd0,  4'd0,  1'b0, '0},
		'{4'd15, 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  1'b0, '0},
		'{4'd0,  4'd0,  4'd0,  4'd0,  4'd15, 4'd0,  1'b0, '0},
		'{4'd0,  4'd15, 4'd0,  4'd0,  4'd0,  4'd0,  1'b0, '0},
		'{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd15, 1'b0, '0},
		'{4'd0,  4'd0,  4'd15, 4'd0,  4'd0,  4'd0,  1'b0, '0},
		'{4'd0,  4'd0,  4'd0,  4'd15, 4'd15, 4'd15, 1'b0, '0},
		'{4'd15, 4'd15, 4'd15, 4'd0,  4'd0,  4'd0,  1'b0, '0},
		'{4'd0,  4'd15, 4'd0,  4'd15, 4'd0,  4'd15, 1'b0, '0},
		'{4'd15, 4'd0,  4'd15, 4'd0,  4'd15, 4'd0,  1'b0, '0},
		'{4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  4'd0,  1'b0, '0},
		'{4'd0,  4'd0,  4'd0,  4'd1,  4'd0,  4'd1,  1'b0, '0},
		'{4'd0,  4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  1'b0, '0},
		'{4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  4'd1,  1'b0, '0},
		'{4'd0,  4'd0,  4'd0,  4'd3,  4'd5,  4'd7,  1'b0, '0},
		'{4'd10, 4'd2,  4'd9,  4'd4,  4'd13, 4'd1,  1'b0, '0},
		'{4'd7,  4'd7,  4'd7,  4'd8,  4'd6,  4'd7,  1'b0, '0},
		'{4'd15, 4'd0,  4'd7,  4'd0,  4'd15, 4'd8,  1'b0, '0}
	};

	logic   clk       = 1'b0;
	logic   arst_n    = 1'b0;
	logic   in_valid  = 1'b0;
	logic   in_stall;
	coord_t start_x   = '0;
	coord_t start_y   = '0;
	coord_t start_z   = '0;
	coord_t end_x     = '0;
	coord_t end_y     = '0;
	coord_t end_z     = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	coord_t voxel_x;
	coord_t voxel_y;
	coord_t voxel_z;
	logic   is_last;

	voxel_t pending_voxels [$];
	int     fault_cnt     = 0;
	int     request_cnt   = 0;
	int     single_cnt    = 0;
	int     voxel_cnt     = 0;
	int     longest_path  = 0;
	int     cycle_cnt     = 0;
	int     hold_left     = 0;
	bit     hold_pending  = 1'b0;
	bit     calm          = 1'b0;

	voxel_line_traversal_3d_core #(
		.GRID_SIZE(GRID_SIZE)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_x   (start_x),
		.start_y   (start_y),
		.start_z   (start_z),
		.end_x     (end_x),
		.end_y     (end_y),
		.end_z     (end_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.voxel_x   (voxel_x),
		.voxel_y   (voxel_y),
		.voxel_z   (voxel_z),
		.is_last   (is_last)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Append one expected voxel behind the ones already waiting
	function automatic void enqueue_voxel(input voxel_t v);
		pending_voxels.insert(pending_voxels.size(), v);
	endfunction

	// Saturate a coordinate to the grid
	function automatic coord_t saturate(input coord_t c);
		return (c >= GRID_SIZE) ? coord_t'(GRID_SIZE - 1) : c;
	endfunction

	// True when axis a reaches its next boundary strictly before axis b
	function automatic bit crosses_first(input dir_t da, input dir_t db,
			input logic [ACC_W-1:0] ta, input logic [ACC_W-1:0] tb);
		if (da == DIR_NONE)
			return 1'b0;
		if (db == DIR_NONE)
			return 1'b1;
		return ta < tb;
	endfunction

	// Walk the line and queue every voxel it visits
	function automatic void predict_path(input coord_t sx, input coord_t sy,
			input coord_t sz, input coord_t ex, input coord_t ey, input coord_t ez);
		coord_t              s [3];
		coord_t              e [3];
		coord_t              pos [3];
		coord_t              span [3];
		coord_t              span_nz [3];
		dir_t                dir [3];
		logic [ACC_W-1:0]    t_cross [3];
		logic [INC_W-1:0]    delta [3];
		logic [PROD_W-1:0]   other;
		int                  steps;
		axis_t               ax;
		s = '{saturate(sx), saturate(sy), saturate(sz)};
		e = '{saturate(ex), saturate(ey), saturate(ez)};
		steps = 0;
		for (int i = 0; i < 3; i++) begin
			if (e[i] > s[i]) begin
				span[i] = e[i] - s[i];
				dir[i] = DIR_PLUS;
			end else if (e[i] < s[i]) begin
				span[i] = s[i] - e[i];
				dir[i] = DIR_MINUS;
			end else begin
				span[i] = '0;
				dir[i] = DIR_NONE;
			end
			span_nz[i] = (span[i] != 0) ? span[i] : coord_t'(1);
			steps += int'(span[i]);
			pos[i] = s[i];
		end
		for (int i = 0; i < 3; i++) begin
			other = span_nz[(i + 1) % 3] * span_nz[(i + 2) % 3];
			t_cross[i] = (dir[i] != DIR_NONE) ? ACC_W'(other) : '0;
			delta[i] = (dir[i] != DIR_NONE) ? INC_W'({other, 1'b0}) : '0;
		end
		enqueue_voxel('{pos[0], pos[1], pos[2], steps == 0});
		for (int k = 1; k <= steps; k++) begin
			// pick the axis whose next crossing comes first, ties as the core breaks them
			if (crosses_first(dir[AXIS_X], dir[AXIS_Y], t_cross[AXIS_X], t_cross[AXIS_Y]))
				ax = crosses_first(dir[AXIS_X], dir[AXIS_Z], t_cross[AXIS_X],
					t_cross[AXIS_Z]) ? AXIS_X : AXIS_Z;
			else
				ax = crosses_first(dir[AXIS_Y], dir[AXIS_Z], t_cross[AXIS_Y],
					t_cross[AXIS_Z]) ? AXIS_Y : AXIS_Z;
			if (dir[ax] == DIR_PLUS)
				pos[ax] = pos[ax] + coord_t'(1);
			else if (dir[ax] == DIR_MINUS)
				pos[ax] = pos[ax] - coord_t'(1);
			t_cross[ax] = t_cross[ax] + ACC_W'(delta[ax]);
			enqueue_voxel('{pos[0], pos[1], pos[2], k == steps});
		end
		if (steps + 1 > longest_path)
			longest_path = steps + 1;
	endfunction

	// Offer one request and hold it until the core takes it
	task automatic offer_request(input coord_t sx, input coord_t sy, input coord_t sz,
			input coord_t ex, input coord_t ey, input coord_t ez);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_x  <= sx;
		start_y  <= sy;
		start_z  <= sz;
		end_x    <= ex;
		end_y    <= ey;
		end_z    <= ez;
		do
			@(posedge clk);
		while (in_stall);
		request_cnt++;
		if ({sx, sy, sz} == {ex, ey, ez})
			single_cnt++;
	endtask

	// Drive output stall: random idling, quiet stretch and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 9);
			end
		end
	end

	// Check each accepted result against the oldest expected voxel
	always @(posedge clk) begin
		voxel_t got;
		voxel_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{voxel_x, voxel_y, voxel_z, is_last};
			voxel_cnt++;
			if (pending_voxels.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= MAX_REPORTS)
					$display("%0t: unexpected voxel (%0d,%0d,%0d) last=%0b", $realtime,
						got.x, got.y, got.z, got.last);
			end else begin
				want = pending_voxels.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
						got.last !== want.last) begin
					fault_cnt++;
					if (fault_cnt <= MAX_REPORTS)
						$display("%0t: expected (%0d,%0d,%0d) last=%0b, got (%0d,%0d,%0d) last=%0b",
							$realtime, want.x, want.y, want.z, want.last,
							got.x, got.y, got.z, got.last);
				end
			end
		end
	end

	// End the run if the core hangs
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d voxels still expected", cycle_cnt,
			pending_voxels.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		coord_t s [3];
		coord_t e [3];
		int     kind;
		int     t;
		path_case_t row;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int n = 0; n < NUM_DIRECTED; n++) begin
			row = path_table[n];
			offer_request(row.sx, row.sy, row.sz, row.ex, row.ey, row.ez);
			if (row.typed)
				enqueue_voxel(row.want);
			else
				predict_path(row.sx, row.sy, row.sz, row.ex, row.ey, row.ez);
		end

		// Random requests
		for (int n = 0; n < NUM_RANDOM; n++) begin
			calm = (n >= 200 && n < 300);
			if (n == 60)
				hold_pending = 1'b1;
			// let every expected voxel come out before going on
			if (n == 120) begin
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (pending_voxels.size() != 0);
			end
			for (int i = 0; i < 3; i++) begin
				s[i] = coord_t'($urandom_range(15));
				e[i] = coord_t'($urandom_range(15));
			end
			kind = $urandom_range(7);
			case (kind)
				0: e = s;
				1: begin
					t = $urandom_range(2);
					for (int i = 0; i < 3; i++)
						if (i != t)
							e[i] = s[i];
				end
				2: begin
					for (int i = 0; i < 3; i++) begin
						t = int'(s[i]) + int'($urandom_range(4)) - 2;
						e[i] = (t < 0) ? coord_t'(0) : (t > 15) ? coord_t'(15) : coord_t'(t);
					end
				end
				default: ;
			endcase
			offer_request(s[0], s[1], s[2], e[0], e[1], e[2]);
			predict_path(s[0], s[1], s[2], e[0], e[1], e[2]);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// Drain the remaining voxels, then watch for strays
		do
			@(posedge clk);
		while (pending_voxels.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_voxels.size() != 0)
			fault_cnt++;

		$display("paths traced: %0d (%0d single-cell), voxels checked: %0d",
			request_cnt, single_cnt, voxel_cnt);
		$display("longest path: %0d voxels, mismatches: %0d, cycles: %0d",
			longest_path, fault_cnt, cycle_cnt);
		if (fault_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
